// ----- design/mkrt_pkg.sv -----
`timescale 1ns / 1ps
// shared types, sizes and helpers for the station table core
// no dependencies; used by the core, front and back modules
package mkrt_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W       = (CNT_W > 8) ? CNT_W : 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic        command;
        logic [47:0] station_addr;
        logic [47:0] ap_addr;
        logic [7:0]  signal_level;
        logic [15:0] sequence_value;
        logic [7:0]  read_slot;
    } in_t;

    typedef struct packed {
        logic        was_known;
        logic [7:0]  slot_used;
        logic        entry_valid;
        logic [47:0] entry_station;
        logic [47:0] entry_ap;
        logic [7:0]  entry_level;
        logic [15:0] entry_sequence;
        logic [8:0]  fill_count;
    } out_t;

    // classified transaction waiting for the back end
    typedef struct packed {
        logic              op;
        logic [47:0]       key;
        logic [47:0]       ap;
        logic [7:0]        level;
        logic [15:0]       seq;
        logic [7:0]        read_slot;
        logic [ADDR_W-1:0] read_addr;
    } q_entry_t;

    typedef struct packed {
        logic [47:0] ap;
        logic [7:0]  level;
        logic [15:0] seq;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    function automatic logic [ADDR_W-1:0] slot_to_addr(input logic [7:0] slot);
        logic [ADDR_W+7:0] ext;
        ext = {{ADDR_W{1'b0}}, slot};
        return ext[ADDR_W-1:0];
    endfunction

    function automatic logic [7:0] addr_to_slot(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W+7:0] ext;
        ext = {8'b0, addr};
        return ext[7:0];
    endfunction

    function automatic logic [8:0] count_to_fill(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+8:0] ext;
        ext = {9'b0, cnt};
        return ext[8:0];
    endfunction

    function automatic logic slot_in_range(input logic [7:0] slot,
                                           input logic [CNT_W-1:0] cnt);
        return CMP_W'(slot) < CMP_W'(cnt);
    endfunction

endpackage

// ----- design/mac_keyed_ring_table_core.sv -----
`timescale 1ns / 1ps
// store: each transaction taken from the queue is checked against the filled entries in turn
//   (count = filled entries), one at a time; the result is registered on a hit or after the last filled slot
// read: RAM read, then output register; an index past the fill count loads the output directly
// the key scan does one key RAM read per cycle; a 2-entry queue keeps input open
// reset clears count, ring pointer, queue and output; table RAMs are not cleared
module mac_keyed_ring_table_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mkrt_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output mkrt_pkg::out_t  out_data
);

    logic                q_valid;
    logic                q_pop;
    mkrt_pkg::q_entry_t  q_head;

    mkrt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_head   (q_head)
    );

    mkrt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_head    (q_head),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- design/mkrt_ram.sv -----
`timescale 1ns / 1ps
// generic single-write, single-read RAM with registered read data
// no dependencies
module mkrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/mkrt_front.sv -----
`timescale 1ns / 1ps
// front end: accepts input transactions, classifies them and queues them
// depends on mkrt_pkg
module mkrt_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mkrt_pkg::in_t       in_data,
    output logic                q_valid,
    input  logic                q_pop,
    output mkrt_pkg::q_entry_t  q_head
);

    mkrt_pkg::q_entry_t                q_mem_reg [mkrt_pkg::QUEUE_DEPTH];
    logic [mkrt_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [mkrt_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [mkrt_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;
    mkrt_pkg::q_entry_t                entry;
    logic                              push;
    logic                              pop;

    localparam logic [mkrt_pkg::QPTR_W-1:0] QLAST =
        mkrt_pkg::QPTR_W'(mkrt_pkg::QUEUE_DEPTH - 1);

    assign in_ready = (cnt_reg != mkrt_pkg::QCNT_W'(mkrt_pkg::QUEUE_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_head   = q_mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        entry.op        = (in_data.command == mkrt_pkg::OP_READ) ? mkrt_pkg::OP_READ
                                                                 : mkrt_pkg::OP_STORE;
        entry.key       = in_data.station_addr;
        entry.ap        = in_data.ap_addr;
        entry.level     = in_data.signal_level;
        entry.seq       = in_data.sequence_value;
        entry.read_slot = in_data.read_slot;
        entry.read_addr = mkrt_pkg::slot_to_addr(in_data.read_slot);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QLAST) ? '0 : wr_ptr_reg + mkrt_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QLAST) ? '0 : rd_ptr_reg + mkrt_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + mkrt_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - mkrt_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

// ----- design/mkrt_back.sv -----
`timescale 1ns / 1ps
// back end: key scan, table update, entry reads and the output register
// depends on mkrt_pkg and mkrt_ram
module mkrt_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  mkrt_pkg::q_entry_t  q_head,
    output logic                out_valid,
    input  logic                out_ready,
    output mkrt_pkg::out_t      out_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    localparam logic [mkrt_pkg::ADDR_W-1:0] LAST_SLOT =
        mkrt_pkg::ADDR_W'(mkrt_pkg::TABLE_DEPTH - 1);
    localparam logic [mkrt_pkg::CNT_W-1:0] FULL_COUNT =
        mkrt_pkg::CNT_W'(mkrt_pkg::TABLE_DEPTH);

    logic [1:0]                   state_reg, state_next;
    logic [mkrt_pkg::ADDR_W-1:0]  chk_reg, chk_next;
    mkrt_pkg::q_entry_t           cur_reg, cur_next;
    logic [mkrt_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [mkrt_pkg::ADDR_W-1:0]  ring_reg, ring_next;
    logic                         out_valid_reg, out_valid_next;
    mkrt_pkg::out_t               out_reg, out_next;

    logic                         out_free;
    logic                         out_load;
    logic                         key_rd_en;
    logic                         rec_rd_en;
    logic [mkrt_pkg::ADDR_W-1:0]  rd_addr;
    logic [47:0]                  key_rd_data;
    logic [mkrt_pkg::REC_W-1:0]   rec_rd_data;
    mkrt_pkg::rec_t               rec_rd;
    logic                         wr_en;
    logic [mkrt_pkg::ADDR_W-1:0]  wr_addr;
    mkrt_pkg::rec_t               wr_rec;
    logic                         do_store;
    logic                         store_hit;
    logic [mkrt_pkg::ADDR_W-1:0]  store_slot;
    mkrt_pkg::q_entry_t           store_src;
    logic                         scan_last;

    assign out_free  = !out_valid_reg || out_ready;
    assign rec_rd    = mkrt_pkg::rec_t'(rec_rd_data);
    assign scan_last = (mkrt_pkg::CNT_W'(chk_reg) + mkrt_pkg::CNT_W'(1)) == count_reg;

    always_comb
    begin
        state_next = state_reg;
        chk_next   = chk_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        ring_next  = ring_reg;
        out_next   = out_reg;
        out_load   = 1'b0;
        q_pop      = 1'b0;
        key_rd_en  = 1'b0;
        rec_rd_en  = 1'b0;
        rd_addr    = '0;
        do_store   = 1'b0;
        store_hit  = 1'b0;
        store_slot = chk_reg;
        store_src  = cur_reg;
        wr_en      = 1'b0;
        wr_addr    = ring_reg;
        wr_rec     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                // start only when the output register will be free at the finish
                if (q_valid && out_free)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    if (q_head.op == mkrt_pkg::OP_READ)
                    begin
                        if (mkrt_pkg::slot_in_range(q_head.read_slot, count_reg))
                        begin
                            key_rd_en  = 1'b1;
                            rec_rd_en  = 1'b1;
                            rd_addr    = q_head.read_addr;
                            state_next = ST_READ;
                        end
                        else
                        begin
                            out_load            = 1'b1;
                            out_next            = '0;
                            out_next.slot_used  = q_head.read_slot;
                            out_next.fill_count = mkrt_pkg::count_to_fill(count_reg);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        do_store  = 1'b1;
                        store_src = q_head;
                    end
                    else
                    begin
                        key_rd_en  = 1'b1;
                        rd_addr    = '0;
                        chk_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // read data belongs to slot chk_reg; next slot is fetched meanwhile
                if (key_rd_data == cur_reg.key)
                begin
                    do_store   = 1'b1;
                    store_hit  = 1'b1;
                    store_slot = chk_reg;
                    state_next = ST_IDLE;
                end
                else if (scan_last)
                begin
                    do_store   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    key_rd_en = 1'b1;
                    rd_addr   = chk_reg + mkrt_pkg::ADDR_W'(1);
                    chk_next  = chk_reg + mkrt_pkg::ADDR_W'(1);
                end
            end
            ST_READ:
            begin
                out_load                = 1'b1;
                out_next                = '0;
                out_next.slot_used      = cur_reg.read_slot;
                out_next.entry_valid    = 1'b1;
                out_next.entry_station  = key_rd_data;
                out_next.entry_ap       = rec_rd.ap;
                out_next.entry_level    = rec_rd.level;
                out_next.entry_sequence = rec_rd.seq;
                out_next.fill_count     = mkrt_pkg::count_to_fill(count_reg);
                state_next              = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_store)
        begin
            wr_en        = 1'b1;
            wr_rec.ap    = store_src.ap;
            wr_rec.level = store_src.level;
            wr_rec.seq   = store_src.seq;
            if (store_hit)
            begin
                wr_addr = store_slot;
            end
            else
            begin
                // miss: write the slot at the ring pointer (the oldest once the table is full)
                wr_addr   = ring_reg;
                ring_next = (ring_reg == LAST_SLOT) ? '0 : ring_reg + mkrt_pkg::ADDR_W'(1);
                if (count_reg != FULL_COUNT)
                begin
                    count_next = count_reg + mkrt_pkg::CNT_W'(1);
                end
            end
            out_load            = 1'b1;
            out_next            = '0;
            out_next.was_known  = store_hit;
            out_next.slot_used  = mkrt_pkg::addr_to_slot(wr_addr);
            out_next.fill_count = mkrt_pkg::count_to_fill(count_next);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ring_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ring_reg      <= ring_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg <= chk_next;
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    mkrt_ram #(
        .WIDTH (48),
        .DEPTH (mkrt_pkg::TABLE_DEPTH)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (store_src.key),
        .rd_en   (key_rd_en),
        .rd_addr (rd_addr),
        .rd_data (key_rd_data)
    );

    mkrt_ram #(
        .WIDTH (mkrt_pkg::REC_W),
        .DEPTH (mkrt_pkg::TABLE_DEPTH)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_rec),
        .rd_en   (rec_rd_en),
        .rd_addr (rd_addr),
        .rd_data (rec_rd_data)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above table depth");

    a_ring_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg < FULL_COUNT) |-> (mkrt_pkg::CNT_W'(ring_reg) == count_reg))
        else $error("ring pointer out of step with count before the table fills");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

    a_scan_in_filled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (mkrt_pkg::CNT_W'(chk_reg) < count_reg))
        else $error("key scan beyond filled entries");

endmodule

// ----- dv/mac_keyed_ring_table_core_test.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the keyed station table core: directed rows, then random traffic
// depends on mkrt_pkg and mac_keyed_ring_table_core
module mac_keyed_ring_table_core_test;

    localparam int LIMIT_CYCLES  = 2000000;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int TAIL_CYCLES   = 300;
    localparam int MAX_WAIT      = 14;

    typedef struct {
        mkrt_pkg::in_t  txn;
        bit             typed;
        mkrt_pkg::out_t want;
    } stim_row_t;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    mkrt_pkg::in_t  in_data;
    logic           out_valid;
    logic           out_ready;
    mkrt_pkg::out_t out_data;

    // shadow of the station table
    logic [47:0] key_tab   [mkrt_pkg::TABLE_DEPTH];
    logic [47:0] ap_tab    [mkrt_pkg::TABLE_DEPTH];
    logic [7:0]  level_tab [mkrt_pkg::TABLE_DEPTH];
    logic [15:0] seq_tab   [mkrt_pkg::TABLE_DEPTH];
    int          tab_fill;
    int          tab_ring;

    mkrt_pkg::out_t answer_q [$];
    stim_row_t      stim_rows [$];
    int             error_count;
    int             cycle_count;
    int             sent_count;
    int             recv_count;

    mac_keyed_ring_table_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    function automatic mkrt_pkg::out_t mk_answer(input logic known, input logic [7:0] slot,
                                       input logic valid, input logic [47:0] station,
                                       input logic [47:0] ap, input logic [7:0] level,
                                       input logic [15:0] seq, input logic [8:0] fill);
        mkrt_pkg::out_t a;
        a.was_known      = known;
        a.slot_used      = slot;
        a.entry_valid    = valid;
        a.entry_station  = station;
        a.entry_ap       = ap;
        a.entry_level    = level;
        a.entry_sequence = seq;
        a.fill_count     = fill;
        return a;
    endfunction

    // updates the shadow table and returns the answer the core must give
    function automatic mkrt_pkg::out_t lookup_predict(input mkrt_pkg::in_t txn);
        mkrt_pkg::out_t ans;
        bit             hit;
        int             slot;
        ans  = '0;
        hit  = 1'b0;
        slot = 0;
        if (txn.command == mkrt_pkg::OP_STORE)
        begin
            // lowest matching slot wins
            for (int i = 0; i < tab_fill; i++)
            begin
                if (!hit && key_tab[i] == txn.station_addr)
                begin
                    hit  = 1'b1;
                    slot = i;
                end
            end
            if (!hit)
            begin
                slot = tab_ring;
                if (tab_fill < mkrt_pkg::TABLE_DEPTH)
                    tab_fill++;
                tab_ring = (slot + 1 >= mkrt_pkg::TABLE_DEPTH) ? 0 : slot + 1;
            end
            key_tab[slot]   = txn.station_addr;
            ap_tab[slot]    = txn.ap_addr;
            level_tab[slot] = txn.signal_level;
            seq_tab[slot]   = txn.sequence_value;
            ans.was_known   = hit;
            ans.slot_used   = slot[7:0];
        end
        else
        begin
            ans.slot_used = txn.read_slot;
            if (int'(txn.read_slot) < tab_fill)
            begin
                ans.entry_valid    = 1'b1;
                ans.entry_station  = key_tab[txn.read_slot];
                ans.entry_ap       = ap_tab[txn.read_slot];
                ans.entry_level    = level_tab[txn.read_slot];
                ans.entry_sequence = seq_tab[txn.read_slot];
            end
        end
        ans.fill_count = tab_fill[8:0];
        return ans;
    endfunction

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    task automatic add_row(input logic cmd, input logic [47:0] key, input logic [47:0] ap,
                           input logic [7:0] level, input logic [15:0] seq,
                           input logic [7:0] slot, input bit typed,
                           input mkrt_pkg::out_t want);
        stim_row_t row;
        row.txn.command        = cmd;
        row.txn.station_addr   = key;
        row.txn.ap_addr        = ap;
        row.txn.signal_level   = level;
        row.txn.sequence_value = seq;
        row.txn.read_slot      = slot;
        row.typed              = typed;
        row.want               = want;
        stim_rows.push_back(row);
    endtask

    task automatic send_txn(input mkrt_pkg::in_t txn, input bit typed,
                            input mkrt_pkg::out_t want);
        int             gap;
        mkrt_pkg::out_t pred;
        // stretches of back-to-back traffic
        gap = (((sent_count / 50) % 5) == 2) ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= txn;
        do
            @(posedge clk);
        while (!in_ready);
        pred = lookup_predict(txn);
        answer_q.push_back(typed ? want : pred);
        sent_count++;
    endtask

    task automatic drain_answers();
        in_valid <= 1'b0;
        @(posedge clk);
        while (answer_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic mkrt_pkg::in_t random_txn();
        mkrt_pkg::in_t txn;
        int            pick;
        txn.command        = mkrt_pkg::OP_STORE;
        txn.station_addr   = rand48();
        txn.ap_addr        = rand48();
        txn.signal_level   = 8'($urandom);
        txn.sequence_value = 16'($urandom);
        txn.read_slot      = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            // refresh a station that is already in the table
            if (tab_fill > 0)
                txn.station_addr = key_tab[$urandom_range(0, tab_fill - 1)];
        end
        else if (pick < 65)
        begin
            // new station, now and then from a tiny key space
            if ($urandom_range(0, 9) == 0)
                txn.station_addr = 48'($urandom_range(0, 7));
        end
        else
        begin
            txn.command = mkrt_pkg::OP_READ;
            if (tab_fill > 0 && $urandom_range(0, 4) != 0)
                txn.read_slot = 8'($urandom_range(0, tab_fill - 1));
        end
        return txn;
    endfunction

    // result side
    initial
    begin
        int             stall;
        mkrt_pkg::out_t want;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = (((recv_count / 70) % 4) == 1) ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            recv_count++;
            if (answer_q.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected transaction, expected none, actual %h", $time,
                         out_data);
            end
            else
            begin
                want = answer_q.pop_front();
                report_field("was_known", 64'(want.was_known), 64'(out_data.was_known));
                report_field("slot_used", 64'(want.slot_used), 64'(out_data.slot_used));
                report_field("entry_valid", 64'(want.entry_valid), 64'(out_data.entry_valid));
                report_field("entry_station", 64'(want.entry_station),
                             64'(out_data.entry_station));
                report_field("entry_ap", 64'(want.entry_ap), 64'(out_data.entry_ap));
                report_field("entry_level", 64'(want.entry_level), 64'(out_data.entry_level));
                report_field("entry_sequence", 64'(want.entry_sequence),
                             64'(out_data.entry_sequence));
                report_field("fill_count", 64'(want.fill_count), 64'(out_data.fill_count));
            end
        end
    end

    // stimulus side
    initial
    begin
        logic [47:0]    ones48;
        mkrt_pkg::out_t none;
        ones48      = '1;
        none        = '0;
        sent_count  = 0;
        tab_fill    = 0;
        tab_ring    = 0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_data     <= '0;

        // empty table, both index extremes
        add_row(mkrt_pkg::OP_READ, 48'h0, 48'h0, 8'h00, 16'h0000, 8'd0, 1'b1,
                mk_answer(1'b0, 8'd0, 1'b0, 48'h0, 48'h0, 8'h00, 16'h0000, 9'd0));
        add_row(mkrt_pkg::OP_READ, ones48, ones48, 8'hff, 16'hffff, 8'd255, 1'b1,
                mk_answer(1'b0, 8'd255, 1'b0, 48'h0, 48'h0, 8'h00, 16'h0000, 9'd0));
        // all-zero and all-one records
        add_row(mkrt_pkg::OP_STORE, 48'h0, 48'h0, 8'h00, 16'h0000, 8'd255, 1'b1,
                mk_answer(1'b0, 8'd0, 1'b0, 48'h0, 48'h0, 8'h00, 16'h0000, 9'd1));
        add_row(mkrt_pkg::OP_STORE, ones48, ones48, 8'hff, 16'hffff, 8'd0, 1'b1,
                mk_answer(1'b0, 8'd1, 1'b0, 48'h0, 48'h0, 8'h00, 16'h0000, 9'd2));
        add_row(mkrt_pkg::OP_READ, ones48, ones48, 8'hff, 16'hffff, 8'd0, 1'b1,
                mk_answer(1'b0, 8'd0, 1'b1, 48'h0, 48'h0, 8'h00, 16'h0000, 9'd2));
        add_row(mkrt_pkg::OP_READ, 48'h0, 48'h0, 8'h00, 16'h0000, 8'd1, 1'b1,
                mk_answer(1'b0, 8'd1, 1'b1, ones48, ones48, 8'hff, 16'hffff, 9'd2));
        // first index past the fill count
        add_row(mkrt_pkg::OP_READ, 48'h0, 48'h0, 8'h00, 16'h0000, 8'd2, 1'b1,
                mk_answer(1'b0, 8'd2, 1'b0, 48'h0, 48'h0, 8'h00, 16'h0000, 9'd2));
        // known stations get their record overwritten in place
        add_row(mkrt_pkg::OP_STORE, 48'h0, 48'ha5a5_a5a5_a5a5, 8'h5a, 16'h1234, 8'd7, 1'b1,
                mk_answer(1'b1, 8'd0, 1'b0, 48'h0, 48'h0, 8'h00, 16'h0000, 9'd2));
        add_row(mkrt_pkg::OP_READ, 48'h0, 48'h0, 8'h00, 16'h0000, 8'd0, 1'b0, none);
        add_row(mkrt_pkg::OP_STORE, ones48, 48'h0, 8'h00, 16'h0000, 8'd128, 1'b1,
                mk_answer(1'b1, 8'd1, 1'b0, 48'h0, 48'h0, 8'h00, 16'h0000, 9'd2));
        add_row(mkrt_pkg::OP_READ, 48'h0, 48'h0, 8'h00, 16'h0000, 8'd1, 1'b0, none);
        add_row(mkrt_pkg::OP_STORE, 48'h0000_0000_0001, 48'h5a5a_5a5a_5a5a, 8'h80, 16'h8000,
                8'd1, 1'b0, none);
        add_row(mkrt_pkg::OP_STORE, 48'h8000_0000_0000, 48'h0000_0000_0001, 8'h01, 16'h0001,
                8'd64, 1'b0, none);
        add_row(mkrt_pkg::OP_READ, 48'h0, 48'h0, 8'h00, 16'h0000, 8'd3, 1'b0, none);
        add_row(mkrt_pkg::OP_READ, 48'h0, 48'h0, 8'h00, 16'h0000, 8'd4, 1'b0, none);
        add_row(mkrt_pkg::OP_READ, 48'h0, 48'h0, 8'h00, 16'h0000, 8'd255, 1'b0, none);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
            send_txn(stim_rows[i].txn, stim_rows[i].typed, stim_rows[i].want);
        drain_answers();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
                drain_answers();
            send_txn(random_txn(), 1'b0, none);
        end
        in_valid <= 1'b0;

        while (answer_q.size() != 0)
            @(posedge clk);
        // catch any stray transaction
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
